// ----- rtl/vcc_pkg.sv -----
// Shared types, tables and constants of the vending change controller.
package vcc_pkg;

  localparam int unsigned COIN_KINDS     = 7;
  localparam int unsigned TUBE_IDX_W     = 3;
  localparam int unsigned NUM_PRICES     = 10;
  localparam int unsigned NUM_COIN_FACES = 9;
  localparam int unsigned STOCK_MAX      = 255;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned RECIP_SHIFT    = 16;

  localparam logic [7:0] PRICE_TABLE [NUM_PRICES] = '{
    8'd9, 8'd8, 8'd9, 8'd9, 8'd13, 8'd12, 8'd15, 8'd12, 8'd3, 8'd2
  };

  // Tubes hold the change coins, largest first.
  localparam logic [6:0] TUBE_VALUE [COIN_KINDS] = '{
    7'd100, 7'd50, 7'd20, 7'd10, 7'd5, 7'd2, 7'd1
  };

  // floor(2^16 / value); the quotient estimate is low by at most one.
  localparam logic [16:0] TUBE_RECIP [COIN_KINDS] = '{
    17'd655, 17'd1310, 17'd3276, 17'd6553, 17'd13107, 17'd32768, 17'd65536
  };

  localparam logic [9:0] COIN_FACES [NUM_COIN_FACES] = '{
    10'd500, 10'd200, 10'd100, 10'd50, 10'd20, 10'd10, 10'd5, 10'd2, 10'd1
  };

  typedef enum logic [1:0] {
    OP_SELECT     = 2'd0,
    OP_COIN       = 2'd1,
    OP_LOAD_STOCK = 2'd2,
    OP_LOAD_TUBE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    STS_AWAIT        = 4'd0,
    STS_INVALID_SEL  = 4'd1,
    STS_SOLD_OUT     = 4'd2,
    STS_BAD_COIN     = 4'd3,
    STS_PAID_EXACT   = 4'd4,
    STS_CHANGE_COINS = 4'd5,
    STS_CHANGE_DONE  = 4'd6,
    STS_CHANGE_SHORT = 4'd7,
    STS_IGNORED      = 4'd8,
    STS_LOADED       = 4'd9
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_DIV   = 3'd1,
    S_GIVE  = 3'd2,
    S_PAY   = 3'd3,
    S_FINAL = 3'd4
  } back_state_t;

  // Classified command handed from the front end to the executor.
  typedef struct packed {
    op_t        op;
    logic       sel_ok;
    logic       coin_ok;
    logic       slot_ok;
    logic [3:0] product;
    logic [9:0] coin;
    logic [3:0] slot;
    logic [9:0] count;
  } cmd_t;

  function automatic logic [7:0] price_of(input logic [3:0] idx);
    logic [7:0] p;
    p = '0;
    if (idx < 4'(NUM_PRICES)) begin
      p = PRICE_TABLE[idx];
    end
    return p;
  endfunction

endpackage

// ----- rtl/vcc_front.sv -----
// Front end: decodes an incoming event and runs the checks that need no state.
module vcc_front import vcc_pkg::*; #(
  parameter int PRODUCT_COUNT = 10
) (
  input  logic        in_valid,
  input  logic [31:0] in_data,
  input  logic [1:0]  in_user,
  output logic        cmd_valid,
  output cmd_t        cmd
);

  logic [3:0] product;
  logic [9:0] coin;
  logic [3:0] slot;
  logic       face_hit;

  assign product = in_data[3:0];
  assign coin    = in_data[13:4];
  assign slot    = in_data[17:14];

  always_comb begin
    face_hit = 1'b0;
    for (int i = 0; i < NUM_COIN_FACES; i++) begin
      if (coin == COIN_FACES[i]) begin
        face_hit = 1'b1;
      end
    end
  end

  always_comb begin
    cmd.op      = op_t'(in_user);
    cmd.product = product;
    cmd.coin    = coin;
    cmd.slot    = slot;
    cmd.count   = in_data[27:18];
    cmd.coin_ok = face_hit;
    cmd.sel_ok  = (product != 4'd0) && (product <= 4'(PRODUCT_COUNT));
    unique case (op_t'(in_user))
      OP_LOAD_STOCK: cmd.slot_ok = slot < 4'(PRODUCT_COUNT);
      OP_LOAD_TUBE:  cmd.slot_ok = slot < 4'(COIN_KINDS);
      OP_SELECT,
      OP_COIN:       cmd.slot_ok = 1'b0;
    endcase
  end

  assign cmd_valid = in_valid;

endmodule

// ----- rtl/vcc_queue.sv -----
// Short command queue between the front end and the executor.
module vcc_queue import vcc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = fill != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/vcc_back.sv -----
// Executor: sale state, stock and tube counts, greedy change walk, result register.
module vcc_back import vcc_pkg::*; #(
  parameter int PRODUCT_COUNT = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [31:0] res_data,
  output logic [3:0]  res_user,
  output logic        res_last
);

  localparam int unsigned PIDX_W = (PRODUCT_COUNT > 1) ? $clog2(PRODUCT_COUNT) : 1;

  back_state_t state, state_next;
  logic        sale_open, sale_open_next;
  logic [3:0]  chosen_index, chosen_index_next;
  logic [9:0]  paid_sum, paid_sum_next;
  logic [7:0]  stock [PRODUCT_COUNT];
  logic [7:0]  stock_next [PRODUCT_COUNT];
  logic [9:0]  tubes [COIN_KINDS];
  logic [9:0]  tubes_next [COIN_KINDS];
  logic [9:0]  change, change_next;
  logic [TUBE_IDX_W-1:0] tube, tube_next;
  logic [9:0]  q_est, q_est_next;
  logic [9:0]  give, give_next;

  logic        out_valid;
  status_t     out_status;
  logic [9:0]  out_amount;
  logic [6:0]  out_denom;
  logic [8:0]  out_count;
  logic        out_last;

  logic        emit;
  status_t     emit_status;
  logic [9:0]  emit_amount;
  logic [6:0]  emit_denom;
  logic [8:0]  emit_count;
  logic        emit_last;

  logic        out_free;
  logic [7:0]  price;
  logic [9:0]  due;
  logic [PIDX_W-1:0] sel_idx;
  logic [3:0]  sel_num;
  logic [10:0] sum;
  logic [26:0] recip_prod;
  logic [16:0] q_times_val;
  logic [16:0] rem;
  logic [6:0]  val;
  logic [9:0]  want;
  logic [16:0] pay_total;
  logic        last_tube;

  assign out_free  = !out_valid || res_ready;
  assign cmd_ready = (state == S_IDLE) && out_free;
  assign price     = price_of(chosen_index);
  assign due       = 10'(price) - paid_sum;
  assign sel_num   = cmd.product - 4'd1;
  assign sel_idx   = sel_num[PIDX_W-1:0];
  assign sum       = 11'(paid_sum) + 11'(cmd.coin);
  assign val       = TUBE_VALUE[tube];
  assign last_tube = tube == TUBE_IDX_W'(COIN_KINDS - 1);

  // quotient estimate for change / tube value
  assign recip_prod  = 27'(change) * 27'(TUBE_RECIP[tube]);
  assign q_times_val = 17'(q_est) * 17'(val);
  assign rem         = 17'(change) - q_times_val;
  assign want        = q_est + 10'(rem >= 17'(val));
  assign pay_total   = 17'(give) * 17'(val);

  always_comb begin
    state_next        = state;
    sale_open_next    = sale_open;
    chosen_index_next = chosen_index;
    paid_sum_next     = paid_sum;
    stock_next        = stock;
    tubes_next        = tubes;
    change_next       = change;
    tube_next         = tube;
    q_est_next        = q_est;
    give_next         = give;
    emit              = 1'b0;
    emit_status       = STS_IGNORED;
    emit_amount       = '0;
    emit_denom        = '0;
    emit_count        = '0;
    emit_last         = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          unique case (cmd.op)
            OP_SELECT: begin
              emit = 1'b1;
              priority if (sale_open) begin
                emit_status = STS_IGNORED;
                emit_amount = due;
              end else if (!cmd.sel_ok) begin
                emit_status = STS_INVALID_SEL;
              end else if (stock[sel_idx] == 8'd0) begin
                emit_status = STS_SOLD_OUT;
              end else begin
                stock_next[sel_idx] = stock[sel_idx] - 8'd1;
                chosen_index_next   = sel_num;
                paid_sum_next       = '0;
                sale_open_next      = 1'b1;
                emit_status         = STS_AWAIT;
                emit_amount         = 10'(price_of(sel_num));
              end
            end
            OP_COIN: begin
              priority if (!sale_open) begin
                emit        = 1'b1;
                emit_status = STS_IGNORED;
              end else if (!cmd.coin_ok) begin
                emit        = 1'b1;
                emit_status = STS_BAD_COIN;
                emit_amount = due;
              end else if (sum < 11'(price)) begin
                paid_sum_next = sum[9:0];
                emit          = 1'b1;
                emit_status   = STS_AWAIT;
                emit_amount   = 10'(11'(price) - sum);
              end else begin
                sale_open_next = 1'b0;
                paid_sum_next  = '0;
                if (sum == 11'(price)) begin
                  emit        = 1'b1;
                  emit_status = STS_PAID_EXACT;
                end else begin
                  change_next = 10'(sum - 11'(price));
                  tube_next   = '0;
                  state_next  = S_DIV;
                end
              end
            end
            OP_LOAD_STOCK: begin
              emit = 1'b1;
              if (cmd.slot_ok) begin
                stock_next[cmd.slot[PIDX_W-1:0]] =
                  (cmd.count > 10'(STOCK_MAX)) ? 8'(STOCK_MAX) : cmd.count[7:0];
                emit_status = STS_LOADED;
              end else begin
                emit_status = STS_IGNORED;
              end
            end
            OP_LOAD_TUBE: begin
              emit = 1'b1;
              if (cmd.slot_ok) begin
                tubes_next[cmd.slot[TUBE_IDX_W-1:0]] = cmd.count;
                emit_status = STS_LOADED;
              end else begin
                emit_status = STS_IGNORED;
              end
            end
          endcase
        end
      end
      S_DIV: begin
        q_est_next = recip_prod[RECIP_SHIFT+9:RECIP_SHIFT];
        state_next = S_GIVE;
      end
      S_GIVE: begin
        give_next = (want < tubes[tube]) ? want : tubes[tube];
        if (give_next != '0) begin
          state_next = S_PAY;
        end else if (last_tube) begin
          state_next = S_FINAL;
        end else begin
          tube_next  = tube + 1'b1;
          state_next = S_DIV;
        end
      end
      S_PAY: begin
        if (out_free) begin
          tubes_next[tube] = tubes[tube] - give;
          change_next      = change - pay_total[9:0];
          emit             = 1'b1;
          emit_status      = STS_CHANGE_COINS;
          emit_amount      = change - pay_total[9:0];
          emit_denom       = val;
          emit_count       = give[8:0];
          emit_last        = 1'b0;
          if (last_tube) begin
            state_next = S_FINAL;
          end else begin
            tube_next  = tube + 1'b1;
            state_next = S_DIV;
          end
        end
      end
      S_FINAL: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = (change == '0) ? STS_CHANGE_DONE : STS_CHANGE_SHORT;
          emit_amount = change;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sale_open    <= 1'b0;
      chosen_index <= '0;
      paid_sum     <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < PRODUCT_COUNT; i++) begin
        stock[i] <= '0;
      end
      for (int i = 0; i < COIN_KINDS; i++) begin
        tubes[i] <= '0;
      end
    end else begin
      state        <= state_next;
      sale_open    <= sale_open_next;
      chosen_index <= chosen_index_next;
      paid_sum     <= paid_sum_next;
      stock        <= stock_next;
      tubes        <= tubes_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (res_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    change <= change_next;
    tube   <= tube_next;
    q_est  <= q_est_next;
    give   <= give_next;
    if (emit) begin
      out_status <= emit_status;
      out_amount <= emit_amount;
      out_denom  <= emit_denom;
      out_count  <= emit_count;
      out_last   <= emit_last;
    end
  end

  assign res_valid = out_valid;
  assign res_user  = out_status;
  assign res_last  = out_last;
  assign res_data  = {6'd0, out_count, out_denom, out_amount};

  a_sale_below_price: assert property (@(posedge clk) disable iff (rst)
    sale_open |-> (paid_sum < 10'(price)))
    else $error("open sale already paid in full");

  a_walk_sale_closed: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !sale_open)
    else $error("change walk with a sale still open");

  a_pay_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAY) |-> (give != '0))
    else $error("pay step with nothing to give");

  a_coin_result_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == STS_CHANGE_COINS) |-> (!out_last && out_denom != '0))
    else $error("change coin result malformed");

endmodule

// ----- rtl/vending_change_controller.sv -----
// Top level of the vending change controller.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+--------------------------------------------
//  s_*      | in  | s_tvalid/s_tready | tuser op; tdata product, coin, slot, count
//  m_*      | out | m_tvalid/m_tready | tuser status; tdata amount, denom, count
//
// Select, rejected coin, partial payment and load events finish in the idle state.
// A payment with change walks seven tubes, each through S_DIV (reciprocal multiply)
// and S_GIVE (correction); a tube that pays also passes S_PAY (payout), then S_FINAL
// gives the final status. The two-entry queue lets events arrive while change is paid.
// rst is synchronous; it clears the sale, stock and tube counts.
// A stalled m_tready holds the result register; the executor waits at its next result.
module vending_change_controller import vcc_pkg::*; #(
  parameter int PRODUCT_COUNT = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // product[3:0], coin_value[13:4], slot[17:14],
                                 // load_count[27:18], zero[31:28]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // amount[9:0], denomination[16:10],
                                 // coin_count[25:17], zero[31:26]
  output logic [3:0]  m_tuser,   // status[3:0]
  output logic        m_tlast
);

  logic front_valid;
  cmd_t front_cmd;
  logic exec_valid;
  logic exec_ready;
  cmd_t exec_cmd;

  vcc_front #(
    .PRODUCT_COUNT(PRODUCT_COUNT)
  ) u_front (
    .in_valid (s_tvalid),
    .in_data  (s_tdata),
    .in_user  (s_tuser),
    .cmd_valid(front_valid),
    .cmd      (front_cmd)
  );

  vcc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(front_valid),
    .push_ready(s_tready),
    .push_data (front_cmd),
    .pop_valid (exec_valid),
    .pop_ready (exec_ready),
    .pop_data  (exec_cmd)
  );

  vcc_back #(
    .PRODUCT_COUNT(PRODUCT_COUNT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(exec_valid),
    .cmd_ready(exec_ready),
    .cmd      (exec_cmd),
    .res_valid(m_tvalid),
    .res_ready(m_tready),
    .res_data (m_tdata),
    .res_user (m_tuser),
    .res_last (m_tlast)
  );

endmodule

// ----- sim/tb_vending_change_controller.sv -----
// Self-checking testbench for the vending change controller: directed table, then random traffic.
module tb_vending_change_controller;
  import vcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_PRODUCTS  = 10;
  localparam int unsigned DIRECTED_ROWS = 25;
  localparam int unsigned RANDOM_ITEMS  = 95;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned REPORT_LIMIT  = 10;

  // One input transfer, plus an optional hand-typed response for the directed rows.
  typedef struct packed {
    op_t        op;
    logic [3:0] product;
    logic [9:0] coin;
    logic [3:0] slot;
    logic [9:0] count;
    logic       pinned;
    status_t    pin_status;
    logic [9:0] pin_amount;
  } vend_cmd_t;

  typedef struct packed {
    status_t    status;
    logic [9:0] amount;
    logic [6:0] denom;
    logic [8:0] coins;
    logic       last;
  } vend_rsp_t;

  localparam vend_cmd_t DIRECTED [DIRECTED_ROWS] = '{
    '{OP_SELECT,     4'd1,  10'd0,    4'd0,  10'd0,    1'b1, STS_SOLD_OUT,    10'd0},
    '{OP_SELECT,     4'd0,  10'd0,    4'd0,  10'd0,    1'b1, STS_INVALID_SEL, 10'd0},
    '{OP_SELECT,     4'd15, 10'd0,    4'd0,  10'd0,    1'b1, STS_INVALID_SEL, 10'd0},
    '{OP_SELECT,     4'd11, 10'd0,    4'd0,  10'd0,    1'b1, STS_INVALID_SEL, 10'd0},
    '{OP_COIN,       4'd0,  10'd100,  4'd0,  10'd0,    1'b1, STS_IGNORED,     10'd0},
    '{OP_LOAD_STOCK, 4'd0,  10'd0,    4'd10, 10'd5,    1'b1, STS_IGNORED,     10'd0},
    '{OP_LOAD_STOCK, 4'd0,  10'd0,    4'd15, 10'd1023, 1'b1, STS_IGNORED,     10'd0},
    '{OP_LOAD_TUBE,  4'd0,  10'd0,    4'd7,  10'd5,    1'b1, STS_IGNORED,     10'd0},
    '{OP_LOAD_TUBE,  4'd0,  10'd0,    4'd15, 10'd1023, 1'b1, STS_IGNORED,     10'd0},
    '{OP_LOAD_STOCK, 4'd0,  10'd0,    4'd0,  10'd1023, 1'b1, STS_LOADED,      10'd0},
    '{OP_LOAD_STOCK, 4'd0,  10'd0,    4'd9,  10'd1,    1'b1, STS_LOADED,      10'd0},
    '{OP_LOAD_STOCK, 4'd0,  10'd0,    4'd4,  10'd0,    1'b1, STS_LOADED,      10'd0},
    '{OP_LOAD_TUBE,  4'd0,  10'd0,    4'd0,  10'd1023, 1'b1, STS_LOADED,      10'd0},
    '{OP_LOAD_TUBE,  4'd0,  10'd0,    4'd3,  10'd2,    1'b1, STS_LOADED,      10'd0},
    '{OP_LOAD_TUBE,  4'd0,  10'd0,    4'd5,  10'd1,    1'b1, STS_LOADED,      10'd0},
    '{OP_SELECT,     4'd5,  10'd0,    4'd0,  10'd0,    1'b1, STS_SOLD_OUT,    10'd0},
    '{OP_SELECT,     4'd1,  10'd0,    4'd0,  10'd0,    1'b0, STS_AWAIT,       10'd0},
    '{OP_SELECT,     4'd10, 10'd0,    4'd0,  10'd0,    1'b0, STS_AWAIT,       10'd0},
    '{OP_COIN,       4'd0,  10'd0,    4'd0,  10'd0,    1'b1, STS_BAD_COIN,    10'd9},
    '{OP_COIN,       4'd0,  10'd1023, 4'd0,  10'd0,    1'b1, STS_BAD_COIN,    10'd9},
    '{OP_COIN,       4'd0,  10'd2,    4'd0,  10'd0,    1'b0, STS_AWAIT,       10'd0},
    '{OP_COIN,       4'd0,  10'd500,  4'd0,  10'd0,    1'b0, STS_AWAIT,       10'd0},
    '{OP_SELECT,     4'd10, 10'd0,    4'd0,  10'd0,    1'b0, STS_AWAIT,       10'd0},
    '{OP_COIN,       4'd0,  10'd2,    4'd0,  10'd0,    1'b0, STS_AWAIT,       10'd0},
    '{OP_SELECT,     4'd10, 10'd0,    4'd0,  10'd0,    1'b1, STS_SOLD_OUT,    10'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;

  vend_cmd_t   cmd_on_bus = '0;
  int unsigned idle_phase = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;

  // machine mirror
  logic        sale_open = 1'b0;
  logic [3:0]  sale_idx = '0;
  logic [9:0]  paid = '0;
  logic [7:0]  stock_m [NUM_PRODUCTS] = '{default: '0};
  logic [9:0]  tubes_m [COIN_KINDS] = '{default: '0};

  vend_rsp_t   event_responses [$];
  vend_rsp_t   due_responses [$];

  vending_change_controller dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void add_response(input status_t st, input int unsigned amt,
                                       input int unsigned den, input int unsigned cnt,
                                       input logic last);
    event_responses.push_back('{st, 10'(amt), 7'(den), 9'(cnt), last});
  endfunction

  // Updates the mirror for one accepted event and lists the responses it causes.
  task automatic apply_vend_event(input op_t op, input logic [3:0] product,
                                  input logic [9:0] coin, input logic [3:0] slot,
                                  input logic [9:0] cnt);
    int unsigned price;
    int unsigned owed;
    int unsigned want;
    int unsigned give;
    logic        face_ok;
    price   = PRICE_TABLE[sale_idx];
    face_ok = 1'b0;
    for (int i = 0; i < NUM_COIN_FACES; i++) begin
      if (coin == COIN_FACES[i]) face_ok = 1'b1;
    end
    event_responses.delete();
    case (op)
      OP_SELECT: begin
        if (sale_open) begin
          add_response(STS_IGNORED, price - paid, 0, 0, 1'b1);
        end else if (product == 4'd0 || product > NUM_PRODUCTS) begin
          add_response(STS_INVALID_SEL, 0, 0, 0, 1'b1);
        end else if (stock_m[product - 4'd1] == 8'd0) begin
          add_response(STS_SOLD_OUT, 0, 0, 0, 1'b1);
        end else begin
          stock_m[product - 4'd1] = stock_m[product - 4'd1] - 8'd1;
          sale_idx  = product - 4'd1;
          paid      = '0;
          sale_open = 1'b1;
          add_response(STS_AWAIT, PRICE_TABLE[product - 4'd1], 0, 0, 1'b1);
        end
      end
      OP_COIN: begin
        if (!sale_open) begin
          add_response(STS_IGNORED, 0, 0, 0, 1'b1);
        end else if (!face_ok) begin
          add_response(STS_BAD_COIN, price - paid, 0, 0, 1'b1);
        end else begin
          owed = paid + coin;
          if (owed < price) begin
            paid = 10'(owed);
            add_response(STS_AWAIT, price - owed, 0, 0, 1'b1);
          end else begin
            sale_open = 1'b0;
            paid      = '0;
            if (owed == price) begin
              add_response(STS_PAID_EXACT, 0, 0, 0, 1'b1);
            end else begin
              owed = owed - price;
              // greedy payout, capped by what each tube holds
              for (int t = 0; t < COIN_KINDS; t++) begin
                want = owed / TUBE_VALUE[t];
                give = (want < tubes_m[t]) ? want : tubes_m[t];
                if (give != 0) begin
                  tubes_m[t] = tubes_m[t] - 10'(give);
                  owed = owed - give * TUBE_VALUE[t];
                  add_response(STS_CHANGE_COINS, owed, TUBE_VALUE[t], give, 1'b0);
                end
              end
              if (owed == 0) add_response(STS_CHANGE_DONE, 0, 0, 0, 1'b1);
              else add_response(STS_CHANGE_SHORT, owed, 0, 0, 1'b1);
            end
          end
        end
      end
      OP_LOAD_STOCK: begin
        if (slot < NUM_PRODUCTS) begin
          stock_m[slot] = (cnt > 10'd255) ? 8'd255 : cnt[7:0];
          add_response(STS_LOADED, 0, 0, 0, 1'b1);
        end else begin
          add_response(STS_IGNORED, 0, 0, 0, 1'b1);
        end
      end
      default: begin
        if (slot < COIN_KINDS) begin
          tubes_m[slot] = cnt;
          add_response(STS_LOADED, 0, 0, 0, 1'b1);
        end else begin
          add_response(STS_IGNORED, 0, 0, 0, 1'b1);
        end
      end
    endcase
  endtask

  task automatic check_response(input vend_rsp_t got);
    vend_rsp_t want;
    if (due_responses.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("unexpected response: status %0d amount %0d denom %0d coins %0d last %0b",
                 got.status, got.amount, got.denom, got.coins, got.last);
    end else begin
      want = due_responses.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("response mismatch: exp status %0d amount %0d denom %0d coins %0d last %0b",
                   want.status, want.amount, want.denom, want.coins, want.last);
          $display("                   got status %0d amount %0d denom %0d coins %0d last %0b",
                   got.status, got.amount, got.denom, got.coins, got.last);
        end
      end
    end
  endtask

  function automatic vend_cmd_t random_cmd();
    vend_cmd_t   c;
    int unsigned pick;
    pick      = $urandom_range(99);
    c.op      = (pick < 30) ? OP_SELECT : (pick < 70) ? OP_COIN :
                (pick < 85) ? OP_LOAD_STOCK : OP_LOAD_TUBE;
    c.product = 4'($urandom_range(15));
    c.coin    = 10'($urandom_range(1023));
    c.slot    = 4'($urandom_range(15));
    c.count   = 10'($urandom_range(1023));
    c.pinned     = 1'b0;
    c.pin_status = STS_AWAIT;
    c.pin_amount = '0;
    case (c.op)
      OP_SELECT: begin
        if ($urandom_range(9) != 0) c.product = 4'($urandom_range(NUM_PRODUCTS, 1));
      end
      OP_COIN: begin
        // half of the good coins come from the small faces only, so exact payments show up
        if ($urandom_range(9) != 0)
          c.coin = COIN_FACES[$urandom_range(NUM_COIN_FACES - 1, $urandom_range(1) * 5)];
      end
      OP_LOAD_STOCK: begin
        if ($urandom_range(6) != 0) c.slot = 4'($urandom_range(NUM_PRODUCTS - 1));
        if ($urandom_range(9) != 0) c.count = 10'($urandom_range(6));
      end
      default: begin
        if ($urandom_range(6) != 0) c.slot = 4'($urandom_range(COIN_KINDS - 1));
        if ($urandom_range(9) != 0) c.count = 10'($urandom_range(12));
      end
    endcase
    return c;
  endfunction

  // Holds tvalid across back-to-back transfers; returns at the accepting edge.
  task automatic send_cmd(input vend_cmd_t c);
    while ($urandom_range(99) < ((idle_phase == 0) ? 25 : (idle_phase == 1) ? 88 : 0)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tuser    <= c.op;
    s_tdata    <= {4'd0, c.count, c.slot, c.coin, c.product};
    cmd_on_bus <= c;
    do @(posedge clk); while (!s_tready);
  endtask

  always @(posedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >=
                         ((idle_phase == 0) ? 88 : (idle_phase == 1) ? 25 : 0));
  end

  always @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      apply_vend_event(op_t'(s_tuser), s_tdata[3:0], s_tdata[13:4], s_tdata[17:14],
                       s_tdata[27:18]);
      if (cmd_on_bus.pinned)
        due_responses.push_back('{cmd_on_bus.pin_status, cmd_on_bus.pin_amount,
                                  7'd0, 9'd0, 1'b1});
      else
        foreach (event_responses[i]) due_responses.push_back(event_responses[i]);
    end
    if (m_tvalid && m_tready)
      check_response(vend_rsp_t'({m_tuser, m_tdata[9:0], m_tdata[16:10], m_tdata[25:17],
                                  m_tlast}));
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i]) send_cmd(DIRECTED[i]);
    // phases: sender light/receiver heavy idling, then swapped, then none
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_phase <= 3 * i / RANDOM_ITEMS;
      send_cmd(random_cmd());
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_responses.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/vcc_pkg.sv
rtl/vcc_front.sv
rtl/vcc_queue.sv
rtl/vcc_back.sv
rtl/vending_change_controller.sv
sim/tb_vending_change_controller.sv
